@@ rtl/multitap_keypad_text_entry_defines.svh @@
// ----------------------------------------------------------------------------
// Multi-tap keypad text entry: assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MULTITAP_KEYPAD_TEXT_ENTRY_DEFINES_SVH
`define MULTITAP_KEYPAD_TEXT_ENTRY_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define MTK_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");
// Next-cycle implication
`define MTK_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`else
`define MTK_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define MTK_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

@@ rtl/mtk_pkg.sv @@
// ----------------------------------------------------------------------------
// mtk_pkg
// Shared types and constants of the multi-tap keypad text entry block.
// ----------------------------------------------------------------------------
package mtk_pkg;

    localparam int MAX_LETTERS_DEF = 5;   // default letter store depth
    localparam int NUM_SLOTS       = 5;   // letter fields in one result
    localparam int CHAR_W          = 7;
    localparam int CNT_W           = 3;
    localparam int MS_W            = 16;
    localparam int TAP_W           = 2;
    localparam int CMP_W           = 5;   // holds any slot index up to 31
    localparam int CFG_W           = 16;
    localparam int RES_W           = NUM_SLOTS * CHAR_W + CNT_W + 2;

    localparam logic [CNT_W-1:0] WORD_LEN_RESET = 3'd5;
    localparam logic [MS_W-1:0]  TIMEOUT_RESET  = 16'd1000;
    localparam logic [MS_W-1:0]  MS_MAX         = 16'hFFFF;

    localparam logic [CHAR_W-1:0] KEY_2    = 7'h32;
    localparam logic [CHAR_W-1:0] KEY_7    = 7'h37;
    localparam logic [CHAR_W-1:0] KEY_9    = 7'h39;
    localparam logic [CHAR_W-1:0] KEY_STAR = 7'h2A;
    localparam logic [CHAR_W-1:0] KEY_HASH = 7'h23;

    localparam logic MODE_KEY  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic REG_WORD_LENGTH = 1'b0;
    localparam logic REG_TIMEOUT_MS  = 1'b1;

    // Letters of keys '2'..'9', four taps each; three-letter keys end on the digit
    localparam logic [CHAR_W-1:0] KEY_LETTERS [8][4] = '{
        '{7'h41, 7'h42, 7'h43, 7'h32},
        '{7'h44, 7'h45, 7'h46, 7'h33},
        '{7'h47, 7'h48, 7'h49, 7'h34},
        '{7'h4A, 7'h4B, 7'h4C, 7'h35},
        '{7'h4D, 7'h4E, 7'h4F, 7'h36},
        '{7'h50, 7'h51, 7'h52, 7'h53},
        '{7'h54, 7'h55, 7'h56, 7'h38},
        '{7'h57, 7'h58, 7'h59, 7'h5A}
    };

    typedef struct packed {
        logic [NUM_SLOTS-1:0][CHAR_W-1:0] letters;
        logic [CNT_W-1:0]                 committed_count;
        logic                             pending_active;
        logic                             word_submitted;
    } mtk_result_t;

endpackage

@@ rtl/mtk_core.sv @@
// ----------------------------------------------------------------------------
// mtk_core
// Entry state, configuration registers and the one-pass update per transaction.
// ----------------------------------------------------------------------------
module mtk_core
    import mtk_pkg::*;
#(
    parameter int MAX_LETTERS = MAX_LETTERS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              item_accept,
    input  logic              item_mode,
    input  logic [CHAR_W-1:0] item_key,
    output mtk_result_t       result
);

    logic [CNT_W-1:0]  word_length_reg;
    logic [MS_W-1:0]   timeout_ms_reg;
    logic [CHAR_W-1:0] store_reg [MAX_LETTERS];
    logic [CHAR_W-1:0] store_next [MAX_LETTERS];
    logic [CNT_W-1:0]  commit_reg, commit_next;
    logic [CHAR_W-1:0] pend_key_reg, pend_key_next;
    logic [TAP_W-1:0]  tap_reg, tap_next;
    logic [MS_W-1:0]   elapsed_reg, elapsed_next;

    logic [CNT_W-1:0]  eff_len;
    logic [MS_W-1:0]   elapsed_inc;
    logic [CNT_W-1:0]  commit_mid;
    logic [TAP_W-1:0]  tap_mid;
    logic [2:0]        row;
    logic              wr_a_en, wr_b_en, clear_all, submit;
    logic [CMP_W-1:0]  wr_a_idx, wr_b_idx;
    logic [CHAR_W-1:0] wr_a_val;
    logic [CHAR_W-1:0] store_w [MAX_LETTERS];
    logic [CNT_W-1:0]  res_count;

    // Zero word length acts as one, oversize as the store depth
    always_comb begin
        if (word_length_reg == '0) begin
            eff_len = CNT_W'(1);
        end else if (CMP_W'(word_length_reg) > CMP_W'(MAX_LETTERS)) begin
            eff_len = CNT_W'(MAX_LETTERS);
        end else begin
            eff_len = word_length_reg;
        end
    end

    assign elapsed_inc = (elapsed_reg == MS_MAX) ? elapsed_reg : elapsed_reg + 16'd1;
    assign row         = 3'(item_key - KEY_2);

    always_comb begin
        commit_next   = commit_reg;
        pend_key_next = pend_key_reg;
        tap_next      = tap_reg;
        elapsed_next  = elapsed_reg;
        commit_mid    = commit_reg;
        tap_mid       = tap_reg;
        wr_a_en       = 1'b0;
        wr_a_idx      = '0;
        wr_a_val      = '0;
        wr_b_en       = 1'b0;
        wr_b_idx      = '0;
        clear_all     = 1'b0;
        submit        = 1'b0;
        res_count     = commit_reg;

        if (item_mode == MODE_TICK) begin
            elapsed_next = elapsed_inc;
            if (pend_key_reg != '0 && elapsed_inc > timeout_ms_reg &&
                commit_reg < eff_len) begin
                commit_next   = commit_reg + 3'd1;
                pend_key_next = '0;
            end
        end else begin
            case (item_key) inside
                [KEY_2:KEY_9]: begin
                    if (item_key == pend_key_reg && elapsed_reg < timeout_ms_reg) begin
                        tap_mid = tap_reg + 2'd1;
                    end else begin
                        if (pend_key_reg != '0 && commit_reg < eff_len) begin
                            commit_mid = commit_reg + 3'd1;
                        end
                        if (commit_mid < eff_len) begin
                            pend_key_next = item_key;
                            tap_mid       = '0;
                        end else begin
                            pend_key_next = '0;
                        end
                    end
                    commit_next  = commit_mid;
                    tap_next     = tap_mid;
                    elapsed_next = '0;
                    if (commit_mid < eff_len && pend_key_next != '0) begin
                        // Three-letter keys wrap after the third tap
                        if (item_key != KEY_7 && item_key != KEY_9 && tap_mid == 2'd3) begin
                            tap_next = '0;
                        end
                        wr_a_en  = 1'b1;
                        wr_a_idx = CMP_W'(commit_mid);
                        wr_a_val = KEY_LETTERS[row][tap_next];
                        wr_b_en  = 1'b1;
                        wr_b_idx = CMP_W'(commit_mid) + CMP_W'(1);
                    end
                end
                KEY_STAR: begin
                    if (pend_key_reg != '0) begin
                        pend_key_next = '0;
                        wr_a_en       = 1'b1;
                        wr_a_idx      = CMP_W'(commit_reg);
                    end else if (commit_reg != '0) begin
                        commit_next = commit_reg - 3'd1;
                        wr_a_en     = 1'b1;
                        wr_a_idx    = CMP_W'(commit_reg - 3'd1);
                    end
                end
                KEY_HASH: begin
                    if (pend_key_reg != '0 && commit_reg < eff_len) begin
                        commit_mid    = commit_reg + 3'd1;
                        pend_key_next = '0;
                    end
                    commit_next = commit_mid;
                    if (commit_mid == eff_len) begin
                        submit        = 1'b1;
                        clear_all     = 1'b1;
                        commit_next   = '0;
                        pend_key_next = '0;
                        tap_next      = '0;
                    end
                end
                default: ;
            endcase
        end
        res_count = submit ? commit_mid : commit_next;
    end

    // Apply the slot writes, then report and optionally clear
    always_comb begin
        for (int i = 0; i < MAX_LETTERS; i++) begin
            store_w[i] = store_reg[i];
            if (wr_a_en && wr_a_idx == CMP_W'(i)) begin
                store_w[i] = wr_a_val;
            end
            if (wr_b_en && wr_b_idx == CMP_W'(i)) begin
                store_w[i] = '0;
            end
            store_next[i] = clear_all ? '0 : store_w[i];
        end
        for (int s = 0; s < NUM_SLOTS; s++) begin
            result.letters[s] = '0;
            if (s < MAX_LETTERS) begin
                result.letters[s] = store_w[s];
            end
        end
        result.committed_count = res_count;
        result.pending_active  = !submit && pend_key_next != '0 && commit_next < eff_len;
        result.word_submitted  = submit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_length_reg <= WORD_LEN_RESET;
            timeout_ms_reg  <= TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_WORD_LENGTH: word_length_reg <= cfg_wdata[CNT_W-1:0];
                REG_TIMEOUT_MS:  timeout_ms_reg  <= cfg_wdata[MS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_LETTERS; i++) begin
                store_reg[i] <= '0;
            end
            commit_reg   <= '0;
            pend_key_reg <= '0;
            tap_reg      <= '0;
            elapsed_reg  <= '0;
        end else if (item_accept) begin
            for (int i = 0; i < MAX_LETTERS; i++) begin
                store_reg[i] <= store_next[i];
            end
            commit_reg   <= commit_next;
            pend_key_reg <= pend_key_next;
            tap_reg      <= tap_next;
            elapsed_reg  <= elapsed_next;
        end
    end

endmodule

@@ rtl/multitap_keypad_text_entry.sv @@
// ----------------------------------------------------------------------------
// multitap_keypad_text_entry
// Multi-tap phone keypad letter entry with commit timeout and word submit.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  key press or 1 ms tick (s_tuser = mode)
// m_*       out  m_tvalid/m_tready  letter slots, count, pending, submitted
// cfg_*     in   cfg_wr_en          word_length (0), timeout_ms (1)
//
// One transaction per cycle while s_tready is high; each result appears in the cycle after its input.
// The output register is the only stage, so s_tready stays high while the
// result is taken or the output is empty.
// Reset: synchronous, active low; clears the letter store and all entry state.
// ----------------------------------------------------------------------------
`include "multitap_keypad_text_entry_defines.svh"

module multitap_keypad_text_entry
    import mtk_pkg::*;
#(
    parameter int MAX_LETTERS = MAX_LETTERS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // key_code[6:0], zero pad [7]
    input  logic             s_tuser,   // mode
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [RES_W-1:0] m_tdata    // letter_0..letter_4, committed_count,
                                        // pending_active, word_submitted
);

    logic              s_accept;
    mtk_result_t       core_res;
    logic              m_valid_reg, m_valid_next;
    logic [RES_W-1:0]  m_data_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    mtk_core #(
        .MAX_LETTERS(MAX_LETTERS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .item_accept (s_accept),
        .item_mode   (s_tuser),
        .item_key    (s_tdata[CHAR_W-1:0]),
        .result      (core_res)
    );

    assign m_valid_next = s_accept || (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Pack lowest field first
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= {core_res.word_submitted, core_res.pending_active,
                           core_res.committed_count,
                           core_res.letters[4], core_res.letters[3], core_res.letters[2],
                           core_res.letters[1], core_res.letters[0]};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `MTK_ASSERT_IMPL(a_submit_not_pending, aclk, aresetn, m_tvalid && m_tdata[RES_W-1], !m_tdata[RES_W-2])
    `MTK_ASSERT_NEXT(a_result_follows, aclk, aresetn, s_accept, m_tvalid)
    `MTK_ASSERT_IMPL(a_pending_below_depth, aclk, aresetn, m_tvalid && m_tdata[RES_W-2], CMP_W'(m_tdata[RES_W-3 -: CNT_W]) < CMP_W'(MAX_LETTERS))

endmodule

@@ dv/keypad_entry_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_entry_checker
// Watches the key/tick stream, the register writes and the display stream of
// the multi-tap keypad block. Keeps its own copy of the letter buffer and
// entry state, predicts one display per accepted transaction and compares it
// field by field against what the block delivers.
// ----------------------------------------------------------------------------
module keypad_entry_checker
    import mtk_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [7:0]       s_tdata,   // key_code[6:0], zero pad [7]
    input  logic             s_tuser,   // mode
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [RES_W-1:0] m_tdata,   // letter_0..letter_4, committed_count,
                                        // pending_active, word_submitted
    output int               mismatch_count,
    output int               results_owed
);

    localparam int LETTER_SLOTS = MAX_LETTERS_DEF;
    localparam int FIELD_COUNT  = NUM_SLOTS + 3;

    logic [CNT_W-1:0]  word_len_reg;
    logic [MS_W-1:0]   timeout_reg;
    logic [CHAR_W-1:0] slot_chars [LETTER_SLOTS];
    logic [CNT_W-1:0]  commit_idx;
    logic [CHAR_W-1:0] held_key;
    logic [TAP_W-1:0]  tap_pos;
    logic [MS_W-1:0]   ms_since_key;
    logic [RES_W-1:0]  expected_displays [$];
    int                faults;

    string field_names [FIELD_COUNT] = '{"letter_0", "letter_1", "letter_2", "letter_3",
                                         "letter_4", "committed_count", "pending_active",
                                         "word_submitted"};

    function automatic logic [RES_W-1:0] pack_display(logic [CNT_W-1:0] count, logic active,
                                                      logic submitted);
        logic [RES_W-1:0] d;
        d = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
            if (i < LETTER_SLOTS) d[i*CHAR_W +: CHAR_W] = slot_chars[i];
        d[NUM_SLOTS*CHAR_W +: CNT_W]    = count;
        d[NUM_SLOTS*CHAR_W + CNT_W]     = active;
        d[NUM_SLOTS*CHAR_W + CNT_W + 1] = submitted;
        return d;
    endfunction

    function automatic logic [CHAR_W-1:0] field_of(logic [RES_W-1:0] d, int f);
        if (f < NUM_SLOTS) return d[f*CHAR_W +: CHAR_W];
        if (f == NUM_SLOTS) return CHAR_W'(d[NUM_SLOTS*CHAR_W +: CNT_W]);
        return CHAR_W'(d[NUM_SLOTS*CHAR_W + CNT_W + (f - NUM_SLOTS - 1)]);
    endfunction

    task automatic put_slot(input int idx, input logic [CHAR_W-1:0] ch);
        if (idx < LETTER_SLOTS) slot_chars[idx] = ch;
    endtask

    task automatic clear_entry();
        for (int i = 0; i < LETTER_SLOTS; i++) slot_chars[i] = '0;
        commit_idx = '0;
        held_key   = '0;
        tap_pos    = '0;
    endtask

    // Advance the entry state by one key press or tick; return the display it shows
    task automatic press_or_tick(input logic mode, input logic [CHAR_W-1:0] key,
                                 output logic [RES_W-1:0] shown);
        int         len;
        int         letter_cnt;
        logic [2:0] row;
        len = word_len_reg;
        if (len < 1) len = 1;
        if (len > LETTER_SLOTS) len = LETTER_SLOTS;

        if (mode == MODE_TICK) begin
            if (ms_since_key != MS_MAX) ms_since_key++;
            if (held_key != '0 && ms_since_key > timeout_reg && commit_idx < len) begin
                commit_idx++;
                held_key = '0;
            end
        end else if (key >= KEY_2 && key <= KEY_9) begin
            if (key == held_key && ms_since_key < timeout_reg) begin
                tap_pos = tap_pos + 1'b1;
            end else begin
                if (held_key != '0 && commit_idx < len) commit_idx++;
                // a full word swallows the new key
                if (commit_idx < len) begin
                    held_key = key;
                    tap_pos  = '0;
                end else begin
                    held_key = '0;
                end
            end
            ms_since_key = '0;
            if (commit_idx < len && held_key != '0) begin
                row        = 3'(key - KEY_2);
                letter_cnt = (key == KEY_7 || key == KEY_9) ? 4 : 3;
                tap_pos    = TAP_W'(tap_pos % letter_cnt);
                put_slot(commit_idx, KEY_LETTERS[row][tap_pos]);
                put_slot(commit_idx + 1, '0);
            end
        end else if (key == KEY_STAR) begin
            if (held_key != '0) begin
                held_key = '0;
                put_slot(commit_idx, '0);
            end else if (commit_idx > 0) begin
                commit_idx--;
                put_slot(commit_idx, '0);
            end
        end else if (key == KEY_HASH) begin
            if (held_key != '0 && commit_idx < len) begin
                commit_idx++;
                held_key = '0;
            end
            if (commit_idx == len) begin
                shown = pack_display(commit_idx, 1'b0, 1'b1);
                clear_entry();
                return;
            end
        end

        shown = pack_display(commit_idx, held_key != '0 && commit_idx < len, 1'b0);
    endtask

    always @(posedge aclk) begin : track
        logic [RES_W-1:0] want;
        if (!aresetn) begin
            word_len_reg = WORD_LEN_RESET;
            timeout_reg  = TIMEOUT_RESET;
            ms_since_key = '0;
            clear_entry();
            expected_displays.delete();
            faults = 0;
        end else begin
            // a display never belongs to the key/tick taken at the same edge
            if (m_tvalid && m_tready) begin
                if (expected_displays.size() == 0) begin
                    $display("%0t: unexpected display expected none actual %h", $time, m_tdata);
                    faults++;
                end else begin
                    want = expected_displays.pop_front();
                    for (int f = 0; f < FIELD_COUNT; f++) begin
                        if (field_of(m_tdata, f) !== field_of(want, f)) begin
                            $display("%0t: %s expected %h actual %h", $time, field_names[f],
                                     field_of(want, f), field_of(m_tdata, f));
                            faults++;
                        end
                    end
                end
            end
            if (cfg_wr_en) begin
                if (cfg_index == REG_WORD_LENGTH) word_len_reg = cfg_wdata[CNT_W-1:0];
                else timeout_reg = cfg_wdata[MS_W-1:0];
            end
            if (s_tvalid && s_tready) begin
                press_or_tick(s_tuser, s_tdata[CHAR_W-1:0], want);
                expected_displays.push_back(want);
            end
        end
        mismatch_count <= faults;
        results_owed   <= expected_displays.size();
    end

endmodule

@@ dv/multitap_keypad_text_entry_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multitap_keypad_text_entry_test
// Drives key presses and millisecond ticks into the keypad entry block under
// a range of word lengths and timeouts, with random idle on both streams,
// a long output hold-off and a tick run under the largest timeout.
// The checker beside the block predicts and compares every display.
// ----------------------------------------------------------------------------
module multitap_keypad_text_entry_test;
    import mtk_pkg::*;

    localparam logic [CHAR_W-1:0] KEY_NUL = 7'h00;
    localparam logic [CHAR_W-1:0] KEY_DEL = 7'h7F;
    localparam logic [CHAR_W-1:0] KEY_0   = 7'h30;
    localparam logic [CHAR_W-1:0] KEY_1   = 7'h31;
    localparam logic [CHAR_W-1:0] KEY_3   = KEY_2 + 7'd1;
    localparam logic [CHAR_W-1:0] KEY_4   = KEY_2 + 7'd2;
    localparam logic [CHAR_W-1:0] KEY_5   = KEY_2 + 7'd3;
    localparam logic [CHAR_W-1:0] KEY_6   = KEY_2 + 7'd4;
    localparam logic [CHAR_W-1:0] KEY_8   = KEY_2 + 7'd6;

    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 155;
    localparam int HOLD_CYCLES    = 300;
    localparam int LONG_TICKS     = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    logic             aclk;
    logic             aresetn   = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic             cfg_index = REG_WORD_LENGTH;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata   = '0;    // key_code[6:0], zero pad [7]
    logic             s_tuser   = MODE_KEY;   // mode
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [RES_W-1:0] m_tdata;   // letter_0..letter_4, committed_count,
                                 // pending_active, word_submitted

    int mismatches;
    int results_owed;
    int quiet_cycles  = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int cur_timeout   = TIMEOUT_RESET;
    bit src_gaps      = 1'b1;
    bit sink_stalls   = 1'b1;

    multitap_keypad_text_entry u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    keypad_entry_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatches),
        .results_owed   (results_owed)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic offer(input logic mode, input logic [CHAR_W-1:0] key);
        int gap;
        gap = src_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {1'b0, key};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_all_shown();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
        repeat (3) @(posedge aclk);
    endtask

    task automatic configure(input int len, input int tmo);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_WORD_LENGTH;
        cfg_wdata   <= CFG_W'(len);
        @(posedge aclk);
        cfg_index   <= REG_TIMEOUT_MS;
        cfg_wdata   <= CFG_W'(tmo);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_timeout = tmo;
    endtask

    // Letter keys with frequent repeats, tick bursts around the timeout,
    // some '#' and '*', and a little noise
    task automatic random_entries(input int count);
        int                done;
        int                r;
        int                burst;
        logic [CHAR_W-1:0] key;
        logic [CHAR_W-1:0] last_key;
        done     = 0;
        last_key = KEY_2;
        while (done < count) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                key = $urandom_range(0, 1) ? last_key : CHAR_W'(KEY_2 + $urandom_range(0, 7));
                last_key = key;
                offer(MODE_KEY, key);
                done++;
            end else if (r < 72) begin
                burst = $urandom_range(1, cur_timeout < 28 ? cur_timeout + 2 : 4);
                repeat (burst) begin
                    offer(MODE_TICK, CHAR_W'($urandom));
                    done++;
                end
            end else if (r < 82) begin
                offer(MODE_KEY, KEY_HASH);
                done++;
            end else if (r < 90) begin
                offer(MODE_KEY, KEY_STAR);
                done++;
            end else begin
                offer(MODE_KEY, CHAR_W'($urandom));
                done++;
            end
        end
    endtask

    // Output side: random stalls, plus the requested long hold-offs
    initial begin
        forever begin
            if (holds_served < hold_requests) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                holds_served++;
            end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int len;
        int tmo;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Two-letter word, 3 ms timeout
        configure(2, 3);
        offer(MODE_KEY, KEY_NUL);
        offer(MODE_KEY, KEY_DEL);
        offer(MODE_KEY, KEY_1);
        offer(MODE_KEY, KEY_0);
        offer(MODE_KEY, KEY_STAR);    // nothing to delete
        offer(MODE_KEY, KEY_HASH);    // empty word, no submit
        repeat (4) offer(MODE_KEY, KEY_2);   // A B C, then wrap to A
        offer(MODE_TICK, KEY_DEL);
        offer(MODE_TICK, 7'h55);
        offer(MODE_TICK, KEY_NUL);    // elapsed equals timeout: no commit
        offer(MODE_KEY, KEY_2);       // repeat at the timeout starts a new letter
        repeat (4) offer(MODE_TICK, KEY_2);  // past the timeout: commit fills the word
        offer(MODE_KEY, KEY_9);       // word full, key dropped
        offer(MODE_KEY, KEY_STAR);    // delete last committed letter
        repeat (4) offer(MODE_KEY, KEY_9);   // W X Y Z
        offer(MODE_KEY, KEY_HASH);    // commit and submit
        wait_all_shown();

        // Shrink the word below the committed count
        configure(5, 1000);
        offer(MODE_KEY, KEY_2);
        offer(MODE_KEY, KEY_3);
        offer(MODE_KEY, KEY_4);
        offer(MODE_KEY, KEY_5);
        offer(MODE_KEY, KEY_HASH);
        wait_all_shown();
        configure(2, 1000);
        offer(MODE_KEY, KEY_6);
        offer(MODE_KEY, KEY_HASH);
        repeat (5) offer(MODE_KEY, KEY_STAR);
        wait_all_shown();

        // Word length zero acts as one
        configure(0, 1);
        offer(MODE_KEY, KEY_8);
        offer(MODE_KEY, KEY_HASH);
        wait_all_shown();

        // Largest timeout: a run of ticks never commits the pending letter
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        configure(1, MS_MAX);
        offer(MODE_KEY, KEY_5);
        repeat (LONG_TICKS) offer(MODE_TICK, CHAR_W'($urandom));
        offer(MODE_KEY, KEY_5);
        offer(MODE_KEY, KEY_HASH);
        wait_all_shown();

        for (int p = 0; p < PHASES; p++) begin
            len = (p < 8) ? p : $urandom_range(0, 7);
            case (p % 4)
                0:       tmo = $urandom_range(1, 4);
                1:       tmo = $urandom_range(5, 20);
                2:       tmo = 1;
                default: tmo = (p == 3) ? MS_MAX : TIMEOUT_RESET;
            endcase
            configure(len, tmo);
            src_gaps    = (p % 3 != 0);
            sink_stalls = (p % 4 != 1);
            // keep offering while the output is held off so the input stalls
            if (p == 4) begin
                src_gaps = 1'b0;
                hold_requests++;
            end
            random_entries(PHASE_ITEMS);
            wait_all_shown();
        end

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/mtk_pkg.sv
rtl/mtk_core.sv
rtl/multitap_keypad_text_entry.sv
dv/keypad_entry_checker.sv
dv/multitap_keypad_text_entry_test.sv
